// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// depends on nothing; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tsuid_pkg.sv =====
// shared types and constants for the timestamp unique id generator
// no dependencies; used by every module of the block
package tsuid_pkg;

   // fixed field widths
   localparam int TIME_WIDTH       = 42;
   localparam int ID_WIDTH         = 63;
   localparam int STATUS_WIDTH     = 2;
   localparam int TOL_WIDTH        = 10;
   localparam int CSR_DATA_WIDTH   = 42;
   localparam int CSR_INDEX_WIDTH  = 2;

   // parameter defaults
   localparam int SEQUENCE_WIDTH_DEFAULT   = 12;
   localparam int NODE_FIELD_WIDTH_DEFAULT = 5;

   // register reset values
   localparam logic [TIME_WIDTH-1:0] EPOCH_RESET     = 42'd1696118400000;
   localparam logic [TOL_WIDTH-1:0]  TOLERANCE_RESET = 10'd10;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WORKER     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DATACENTER = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EPOCH      = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE  = 2'd3;

   // request operation codes
   localparam logic OP_UPDATE  = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // result status codes
   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK      = 2'd0,
      ST_BACK    = 2'd1,
      ST_EXHAUST = 2'd2,
      ST_BUSY    = 2'd3
   } status_type;

   // outcome of one request in the generator
   typedef struct packed {
      logic       emit;
      status_type status;
   } gen_result_type;

endpackage

// ===== hw/rtl/tsuid_cfg.sv =====
// configuration registers of the id generator
// depends on tsuid_pkg
module tsuid_cfg #(
   parameter int NODE_FIELD_WIDTH = tsuid_pkg::NODE_FIELD_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write_enable,
   input  logic [tsuid_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [tsuid_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data,
   output logic [NODE_FIELD_WIDTH-1:0]               worker_number,
   output logic [NODE_FIELD_WIDTH-1:0]               datacenter_number,
   output logic [tsuid_pkg::TIME_WIDTH-1:0]          epoch_ms,
   output logic [tsuid_pkg::TOL_WIDTH-1:0]           backward_tolerance_ms
);

   logic [NODE_FIELD_WIDTH-1:0]      worker_ff;
   logic [NODE_FIELD_WIDTH-1:0]      datacenter_ff;
   logic [tsuid_pkg::TIME_WIDTH-1:0] epoch_ff;
   logic [tsuid_pkg::TOL_WIDTH-1:0]  tolerance_ff;

   // register writes, values masked to field width
   always_ff @(posedge clock) begin
      if (reset) begin
         worker_ff     <= '0;
         datacenter_ff <= '0;
         epoch_ff      <= tsuid_pkg::EPOCH_RESET;
         tolerance_ff  <= tsuid_pkg::TOLERANCE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            tsuid_pkg::CSR_WORKER: begin
               worker_ff <= csr_write_data[NODE_FIELD_WIDTH-1:0];
            end
            tsuid_pkg::CSR_DATACENTER: begin
               datacenter_ff <= csr_write_data[NODE_FIELD_WIDTH-1:0];
            end
            tsuid_pkg::CSR_EPOCH: begin
               epoch_ff <= csr_write_data[tsuid_pkg::TIME_WIDTH-1:0];
            end
            tsuid_pkg::CSR_TOLERANCE: begin
               tolerance_ff <= csr_write_data[tsuid_pkg::TOL_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign worker_number         = worker_ff;
   assign datacenter_number     = datacenter_ff;
   assign epoch_ms              = epoch_ff;
   assign backward_tolerance_ms = tolerance_ff;

endmodule

// ===== hw/rtl/tsuid_gen.sv =====
// sequence state and per-request decision logic of the id generator
// depends on tsuid_pkg
module tsuid_gen #(
   parameter int SEQUENCE_WIDTH   = tsuid_pkg::SEQUENCE_WIDTH_DEFAULT,
   parameter int NODE_FIELD_WIDTH = tsuid_pkg::NODE_FIELD_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 operation,
   input  logic [tsuid_pkg::TIME_WIDTH-1:0]     now_ms,
   input  logic [NODE_FIELD_WIDTH-1:0]          worker_number,
   input  logic [NODE_FIELD_WIDTH-1:0]          datacenter_number,
   input  logic [tsuid_pkg::TIME_WIDTH-1:0]     epoch_ms,
   input  logic [tsuid_pkg::TOL_WIDTH-1:0]      backward_tolerance_ms,
   output tsuid_pkg::gen_result_type            result,
   output logic [tsuid_pkg::ID_WIDTH-1:0]       id_value
);

   localparam int DC_POS   = SEQUENCE_WIDTH + NODE_FIELD_WIDTH;
   localparam int TIME_POS = SEQUENCE_WIDTH + 2 * NODE_FIELD_WIDTH;
   localparam int TW       = tsuid_pkg::TIME_WIDTH;
   localparam int IW       = tsuid_pkg::ID_WIDTH;

   logic [TW-1:0]             last_ms_ff, last_ms_in;
   logic                      have_last_ff, have_last_in;
   logic [SEQUENCE_WIDTH-1:0] seq_ff, seq_in;
   logic [SEQUENCE_WIDTH:0]   back_count_ff, back_count_in;
   logic                      waiting_ff, waiting_in;

   logic [TW-1:0]             rel_ms;
   logic [TW-1:0]             back_diff;
   logic [SEQUENCE_WIDTH-1:0] seq_next;
   logic [SEQUENCE_WIDTH-1:0] id_seq;
   logic                      is_request;
   logic                      step_back;
   logic                      same_ms;

   // shared arithmetic
   assign is_request = (operation == tsuid_pkg::OP_REQUEST);
   assign rel_ms     = now_ms - epoch_ms;
   assign back_diff  = last_ms_ff - now_ms;
   assign seq_next   = seq_ff + 1'b1;
   assign step_back  = have_last_ff && (now_ms < last_ms_ff);
   assign same_ms    = have_last_ff && (now_ms == last_ms_ff);

   // decision and next state
   always_comb begin
      last_ms_in     = last_ms_ff;
      have_last_in   = have_last_ff;
      seq_in         = seq_ff;
      back_count_in  = back_count_ff;
      waiting_in     = waiting_ff;
      result.emit    = 1'b0;
      result.status  = tsuid_pkg::ST_OK;
      id_seq         = '0;
      if (waiting_ff) begin
         if (is_request) begin
            result.emit   = 1'b1;
            result.status = tsuid_pkg::ST_BUSY;
         end else if (now_ms > last_ms_ff) begin
            // held id released by a later time
            result.emit = 1'b1;
            last_ms_in  = now_ms;
            seq_in      = '0;
            waiting_in  = 1'b0;
         end
      end else if (is_request) begin
         if (step_back) begin
            if (back_diff > TW'(backward_tolerance_ms)) begin
               result.emit   = 1'b1;
               result.status = tsuid_pkg::ST_BACK;
            end else begin
               // compensation count saturates at all ones
               if (back_count_ff != '1) begin
                  back_count_in = back_count_ff + 1'b1;
               end
               result.emit = 1'b1;
               if (back_count_ff[SEQUENCE_WIDTH]) begin
                  result.status = tsuid_pkg::ST_EXHAUST;
               end else begin
                  last_ms_in   = now_ms;
                  have_last_in = 1'b1;
                  seq_in       = '0;
               end
            end
         end else if (same_ms) begin
            seq_in = seq_next;
            if (seq_next == '0) begin
               waiting_in = 1'b1;
            end else begin
               result.emit = 1'b1;
               id_seq      = seq_next;
            end
         end else begin
            // new millisecond
            result.emit  = 1'b1;
            last_ms_in   = now_ms;
            have_last_in = 1'b1;
            seq_in       = '0;
         end
      end
   end

   // id packing, zero unless status is ok
   always_comb begin
      if (result.status == tsuid_pkg::ST_OK) begin
         id_value = (IW'(rel_ms) << TIME_POS)
                  | (IW'(datacenter_number) << DC_POS)
                  | (IW'(worker_number) << SEQUENCE_WIDTH)
                  | IW'(id_seq);
      end else begin
         id_value = '0;
      end
   end

   // state registers, updated as the request leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ms_ff    <= '0;
         have_last_ff  <= 1'b0;
         seq_ff        <= '0;
         back_count_ff <= '0;
         waiting_ff    <= 1'b0;
      end else if (advance) begin
         last_ms_ff    <= last_ms_in;
         have_last_ff  <= have_last_in;
         seq_ff        <= seq_in;
         back_count_ff <= back_count_in;
         waiting_ff    <= waiting_in;
      end
   end

endmodule

// ===== hw/rtl/timestamp_unique_id_generator_core.sv =====
// top level of the timestamp unique id generator
// depends on tsuid_pkg, tsuid_cfg and tsuid_gen
//
// Generates 63-bit time-ordered ids: (time - epoch), datacenter, worker and a
// per-millisecond sequence. A request is taken into an input register, decided
// combinationally against the sequence state, and its result (if any) is
// written to an output register as the request leaves the input register;
// the receiver takes it from the output register. One request
// is accepted every cycle; the only throttle is a stalled output register
// holding a result while the input register is also full. Requests with
// operation update produce no result unless they release an id held after a
// sequence wrap. Configuration writes are meant for idle periods.
module timestamp_unique_id_generator_core #(
   parameter int SEQUENCE_WIDTH   = tsuid_pkg::SEQUENCE_WIDTH_DEFAULT,
   parameter int NODE_FIELD_WIDTH = tsuid_pkg::NODE_FIELD_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_operation,
   input  logic [tsuid_pkg::TIME_WIDTH-1:0]      req_now_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tsuid_pkg::ID_WIDTH-1:0]        rsp_id_value,
   output logic [tsuid_pkg::STATUS_WIDTH-1:0]    rsp_status,
   input  logic                                  csr_write_enable,
   input  logic [tsuid_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tsuid_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic                                in_valid_ff, in_valid_in;
   logic                                in_op_ff;
   logic [tsuid_pkg::TIME_WIDTH-1:0]    in_now_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tsuid_pkg::ID_WIDTH-1:0]      rsp_id_ff;
   tsuid_pkg::status_type               rsp_status_ff;

   logic                                accept;
   logic                                out_free;
   logic                                advance;
   tsuid_pkg::gen_result_type           gen_result;
   logic [tsuid_pkg::ID_WIDTH-1:0]      gen_id;

   logic [NODE_FIELD_WIDTH-1:0]         worker_number;
   logic [NODE_FIELD_WIDTH-1:0]         datacenter_number;
   logic [tsuid_pkg::TIME_WIDTH-1:0]    epoch_ms;
   logic [tsuid_pkg::TOL_WIDTH-1:0]     backward_tolerance_ms;

   // configuration registers
   tsuid_cfg #(
      .NODE_FIELD_WIDTH (NODE_FIELD_WIDTH)
   ) u_cfg (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .worker_number         (worker_number),
      .datacenter_number     (datacenter_number),
      .epoch_ms              (epoch_ms),
      .backward_tolerance_ms (backward_tolerance_ms)
   );

   // handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? gen_result.emit : (rsp_valid_ff && rsp_stall);

   // decision logic and sequence state
   tsuid_gen #(
      .SEQUENCE_WIDTH   (SEQUENCE_WIDTH),
      .NODE_FIELD_WIDTH (NODE_FIELD_WIDTH)
   ) u_gen (
      .clock                 (clock),
      .reset                 (reset),
      .advance               (advance),
      .operation             (in_op_ff),
      .now_ms                (in_now_ff),
      .worker_number         (worker_number),
      .datacenter_number     (datacenter_number),
      .epoch_ms              (epoch_ms),
      .backward_tolerance_ms (backward_tolerance_ms),
      .result                (gen_result),
      .id_value              (gen_id)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff  <= req_operation;
         in_now_ff <= req_now_ms;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_id_ff     <= gen_id;
         rsp_status_ff <= gen_result.status;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_id_value = rsp_id_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ===== hw/rtl/tsuid_checker.sv =====
// port-level checks for the timestamp unique id generator
// depends on tsuid_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module tsuid_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [tsuid_pkg::ID_WIDTH-1:0]     rsp_id_value,
   input logic [tsuid_pkg::STATUS_WIDTH-1:0] rsp_status
);

   // no result right after reset
   `ASSERT_CLK_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // input stalls only behind a held result
   `ASSERT_CLK(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "input stalled without a held result")

   // failed requests carry a zero id
   `ASSERT_CLK(a_zero_id, clock, reset, (rsp_valid && (rsp_status != tsuid_pkg::ST_OK)) |-> (rsp_id_value == '0), "nonzero id with error status")

   // a stalled result holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_id_value) && $stable(rsp_status)), "stalled result changed")

endmodule

bind timestamp_unique_id_generator_core tsuid_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_id_value (rsp_id_value),
   .rsp_status   (rsp_status)
);
